// ----- rtl/icc_pkg.sv -----
// ---------------------------------------------------------------------------
// icc_pkg: shared types and constants of the identifier case converter
// Beat formats, style codes and the slot count of the result queue.
// ---------------------------------------------------------------------------
package icc_pkg;

  // Result queue slots (at least 2: one item can give two results)
  localparam int ICC_FIFO_DEPTH = 4;

  // Input beat: one byte of the string and the end-of-string mark
  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } icc_in_t;

  // Result beat: byte, byte-present flag and end-of-string mark
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_valid;
    logic       out_last;
  } icc_out_t;

  // Results of one input beat, ready to be queued
  typedef struct packed {
    logic [1:0] num;
    icc_out_t   first;
    icc_out_t   second;
  } icc_push_t;

  // Style codes; unlisted codes behave as copy
  typedef enum logic [4:0] {
    STY_COPY       = 5'd0,
    STY_CAMEL      = 5'd1,
    STY_CAPITAL    = 5'd2,
    STY_CONSTANT   = 5'd3,
    STY_DOT        = 5'd4,
    STY_HEADER     = 5'd5,
    STY_NO         = 5'd6,
    STY_PARAM      = 5'd7,
    STY_PASCAL     = 5'd8,
    STY_PATH       = 5'd9,
    STY_SENTENCE   = 5'd10,
    STY_SNAKE      = 5'd11,
    STY_TITLE      = 5'd12,
    STY_SWAP       = 5'd13,
    STY_LOWER      = 5'd14,
    STY_LOWERFIRST = 5'd15,
    STY_UPPER      = 5'd16,
    STY_UPPERFIRST = 5'd17,
    STY_SPONGE     = 5'd18
  } icc_style_t;

  // Separator and break characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_NUL    = 8'h00;

endpackage

// ----- rtl/icc_xlate.sv -----
// ---------------------------------------------------------------------------
// icc_xlate: per-character case conversion
// Holds the word-splitting flags of the current string and turns one input
// beat into zero, one or two result beats in a single pass.
// ---------------------------------------------------------------------------
module icc_xlate
  import icc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  icc_in_t    in_data,
  input  logic [4:0] style,
  output icc_push_t  push
);

  // String flags
  logic prev_lower_r, prev_lower_nxt;
  logic skip_r,       skip_nxt;
  logic brk_pend_r,   brk_pend_nxt;
  logic none_out_r,   none_out_nxt;
  logic prev_brk_r,   prev_brk_nxt;
  logic odd_r,        odd_nxt;

  function automatic logic is_up(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lo(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic [7:0] to_lo(input logic [7:0] c);
    return is_up(c) ? (c | 8'h20) : c;
  endfunction

  function automatic logic [7:0] to_up(input logic [7:0] c);
    return is_lo(c) ? (c & 8'hDF) : c;
  endfunction

  // Convert one beat and work out the next flags
  always_comb begin
    logic [7:0] c;
    logic       blank;
    logic       sep;
    logic       word;
    logic       do_brk;
    logic       brk_out;
    logic [7:0] brk_char;
    logic       char_out;
    logic [7:0] res_char;
    logic       none_c;
    logic       prev_brk_c;
    logic       cap;
    logic [1:0] n;
    icc_style_t sty;

    c          = in_data.in_char;
    sty        = icc_style_t'(style);
    blank      = (c == CH_SPACE) || (c == CH_TAB);
    sep        = blank || (c == CH_DOT) || (c == CH_USCORE) ||
                 (c == CH_SLASH) || (c == CH_HYPHEN);
    word       = (style >= 5'(STY_CAMEL)) && (style <= 5'(STY_TITLE));
    do_brk     = 1'b0;
    brk_out    = 1'b0;
    brk_char   = CH_SPACE;
    char_out   = 1'b0;
    res_char   = c;
    cap        = 1'b0;
    none_c     = none_out_r;
    prev_brk_c = prev_brk_r;

    skip_nxt     = skip_r;
    brk_pend_nxt = brk_pend_r;
    none_out_nxt = none_out_r;
    prev_brk_nxt = prev_brk_r;

    if (word) begin
      if (!(skip_r && blank)) begin
        skip_nxt = 1'b0;
        if (sep) begin
          brk_pend_nxt = 1'b1;
        end else begin
          brk_pend_nxt = 1'b0;
          do_brk       = brk_pend_r || (prev_lower_r && is_up(c));
          // Pick the break character; camel and pascal drop inner breaks
          unique case (sty)
            STY_DOT:                begin brk_char = CH_DOT;    brk_out = 1'b1; end
            STY_CONSTANT, STY_SNAKE: begin brk_char = CH_USCORE; brk_out = 1'b1; end
            STY_HEADER, STY_PARAM:  begin brk_char = CH_HYPHEN; brk_out = 1'b1; end
            STY_PATH:               begin brk_char = CH_SLASH;  brk_out = 1'b1; end
            STY_CAMEL, STY_PASCAL:  begin brk_char = CH_SPACE;  brk_out = none_out_r; end
            default:                begin brk_char = CH_SPACE;  brk_out = 1'b1; end
          endcase
          brk_out = brk_out && do_brk;
          if (do_brk) begin
            none_c     = 1'b0;
            prev_brk_c = 1'b1;
          end
          // Capitalize by style
          unique case (sty)
            STY_CAPITAL, STY_HEADER, STY_PASCAL, STY_TITLE: cap = none_c || prev_brk_c;
            STY_CAMEL:    cap = !none_c && prev_brk_c;
            STY_SENTENCE: cap = none_c;
            STY_CONSTANT: cap = 1'b1;
            default:      cap = 1'b0;
          endcase
          char_out     = 1'b1;
          res_char     = cap ? to_up(to_lo(c)) : to_lo(c);
          none_out_nxt = 1'b0;
          prev_brk_nxt = 1'b0;
        end
      end
    end else begin
      // Plain styles map byte to byte
      unique case (sty)
        STY_SWAP:       res_char = is_up(c) ? to_lo(c) : to_up(c);
        STY_LOWER:      res_char = to_lo(c);
        STY_LOWERFIRST: res_char = none_out_r ? to_lo(c) : c;
        STY_UPPER:      res_char = to_up(c);
        STY_UPPERFIRST: res_char = none_out_r ? to_up(c) : c;
        STY_SPONGE:     res_char = odd_r ? to_lo(c) : to_up(c);
        default:        res_char = c;
      endcase
      char_out     = 1'b1;
      skip_nxt     = 1'b0;
      none_out_nxt = 1'b0;
      prev_brk_nxt = 1'b0;
    end

    prev_lower_nxt = is_lo(c);
    odd_nxt        = !odd_r;

    // Assemble results: break first, then the character
    n = {1'b0, brk_out} + {1'b0, char_out};
    push.first.out_char  = brk_out ? brk_char : res_char;
    push.first.out_valid = 1'b1;
    push.first.out_last  = in_data.in_last && (n == 2'd1);
    push.second.out_char  = res_char;
    push.second.out_valid = 1'b1;
    push.second.out_last  = in_data.in_last;

    // Bare end marker when the last byte gives nothing
    if (in_data.in_last && (n == 2'd0)) begin
      n                    = 2'd1;
      push.first.out_char  = CH_NUL;
      push.first.out_valid = 1'b0;
      push.first.out_last  = 1'b1;
    end
    push.num = accept ? n : 2'd0;

    // Restart flags at end of string
    if (in_data.in_last) begin
      prev_lower_nxt = 1'b0;
      skip_nxt       = 1'b1;
      brk_pend_nxt   = 1'b0;
      none_out_nxt   = 1'b1;
      prev_brk_nxt   = 1'b0;
      odd_nxt        = 1'b0;
    end
  end

  // Advance flags on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_lower_r <= 1'b0;
      skip_r       <= 1'b1;
      brk_pend_r   <= 1'b0;
      none_out_r   <= 1'b1;
      prev_brk_r   <= 1'b0;
      odd_r        <= 1'b0;
    end else if (accept) begin
      prev_lower_r <= prev_lower_nxt;
      skip_r       <= skip_nxt;
      brk_pend_r   <= brk_pend_nxt;
      none_out_r   <= none_out_nxt;
      prev_brk_r   <= prev_brk_nxt;
      odd_r        <= odd_nxt;
    end
  end

endmodule

// ----- rtl/icc_fifo.sv -----
// ---------------------------------------------------------------------------
// icc_fifo: result queue
// Takes up to two result beats per cycle and hands out one per cycle while the output is not stalled.
// Asks for a stall while fewer than two slots are free.
// ---------------------------------------------------------------------------
module icc_fifo
  import icc_pkg::*;
#(
  parameter int DEPTH = ICC_FIFO_DEPTH
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  icc_push_t push,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output icc_out_t  out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  icc_out_t        slot_r [DEPTH];
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [PW-1:0]   wr_ptr_p1;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop       = (cnt_r != '0) && !out_stall;
  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);

  // Pointer and fill count update
  always_comb begin
    cnt_nxt    = cnt_r + CW'(push.num) - CW'(pop);
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    unique case (push.num)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      slot_r[wr_ptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      slot_r[wr_ptr_p1] <= push.second;
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_data  = slot_r[rd_ptr_r];
  assign full      = (cnt_r > CW'(DEPTH - 2));

endmodule

// ----- rtl/identifier_case_converter.sv -----
// ---------------------------------------------------------------------------
// identifier_case_converter: streaming identifier re-casing
// Re-cases one ASCII string, one byte per beat, into the style in cfg.
// ---------------------------------------------------------------------------
// Each accepted byte is converted in the cycle it is accepted and gives zero,
// one or two result beats (a word break and a character), which go into a
// small result queue; results leave at most one per cycle. A byte is taken
// every cycle while the queue has two free slots, so a string goes through
// at one byte per cycle whenever every byte yields at most one result and
// the output is not stalled. A result is registered in the queue and
// leaves once the results ahead of it have left. The style register
// must only be written while no string is in flight.
module identifier_case_converter
  import icc_pkg::*;
#(
  parameter int FIFO_DEPTH = ICC_FIFO_DEPTH
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  icc_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output icc_out_t   out_data
);

  logic [4:0] style_r;
  logic       accept;
  icc_push_t  push;

  // Hold the style register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      style_r <= 5'(STY_COPY);
    end else if (cfg_we) begin
      style_r <= cfg_wdata;
    end
  end

  assign accept = in_valid && !in_stall;

  icc_xlate u_xlate (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .style   (style_r),
    .push    (push)
  );

  icc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: identifier case converter
// Streams strings into the converter under every listed style code and unused codes, predicts each
// re-cased result beat alongside the block and checks every beat that leaves
// it, with random sender bursts, receiver stalls and one long output hold.
// ---------------------------------------------------------------------------
module testbench;
  import icc_pkg::*;

  localparam int ITEMS_TOTAL = 1350;
  localparam int HOLD_LONG   = 80;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     cfg_we    = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  icc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  icc_out_t out_data;

  identifier_case_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Predictor state: style register and per-string flags
  logic [4:0] style_reg    = STY_COPY;
  bit         prev_lower   = 1'b0;
  bit         skip_lead    = 1'b1;
  bit         brk_pending  = 1'b0;
  bit         none_out     = 1'b1;
  bit         last_was_brk = 1'b0;
  bit         odd_pos      = 1'b0;

  icc_out_t   step_res [2];
  int         step_n;
  icc_out_t   recased_q [$];

  int         mismatch_count = 0;
  int         items_sent     = 0;
  int         stall_pct      = 0;
  int         hold_cycles    = 0;
  int         burst_left     = 0;
  bit         gaps_on        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_upper(logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic bit is_lower(logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic logic [7:0] lower_of(logic [7:0] c);
    return is_upper(c) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] upper_of(logic [7:0] c);
    return is_lower(c) ? c - 8'd32 : c;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic bit is_sep(logic [7:0] c);
    return is_blank(c) || c == CH_DOT || c == CH_USCORE || c == CH_SLASH || c == CH_HYPHEN;
  endfunction

  function automatic void clear_string_state();
    prev_lower   = 1'b0;
    skip_lead    = 1'b1;
    brk_pending  = 1'b0;
    none_out     = 1'b1;
    last_was_brk = 1'b0;
    odd_pos      = 1'b0;
  endfunction

  function automatic void emit(logic [7:0] ch);
    step_res[step_n] = '{out_char: ch, out_valid: 1'b1, out_last: 1'b0};
    step_n++;
  endfunction

  // Work out the result beats of one accepted byte and queue them
  function automatic void recase_byte(logic [7:0] c, logic last);
    logic [7:0] r;
    logic [7:0] lc;
    bit         cap;
    step_n = 0;
    if (style_reg >= STY_CAMEL && style_reg <= STY_TITLE) begin
      if (!(skip_lead && is_blank(c))) begin
        skip_lead = 1'b0;
        if (is_sep(c)) begin
          brk_pending = 1'b1;
        end else begin
          // word break: pending separator run or a lower-to-upper step
          if (brk_pending || (prev_lower && is_upper(c))) begin
            brk_pending = 1'b0;
            case (style_reg)
              STY_DOT:                 emit(CH_DOT);
              STY_CONSTANT, STY_SNAKE: emit(CH_USCORE);
              STY_HEADER, STY_PARAM:   emit(CH_HYPHEN);
              STY_PATH:                emit(CH_SLASH);
              STY_CAMEL, STY_PASCAL: begin
                if (none_out) emit(CH_SPACE);
              end
              default:                 emit(CH_SPACE);
            endcase
            none_out     = 1'b0;
            last_was_brk = 1'b1;
          end
          // letter, capitalized by style
          case (style_reg)
            STY_CAPITAL, STY_HEADER, STY_PASCAL, STY_TITLE: cap = none_out || last_was_brk;
            STY_CAMEL:    cap = !none_out && last_was_brk;
            STY_SENTENCE: cap = none_out;
            STY_CONSTANT: cap = 1'b1;
            default:      cap = 1'b0;
          endcase
          lc = lower_of(c);
          emit(cap ? upper_of(lc) : lc);
          none_out     = 1'b0;
          last_was_brk = 1'b0;
        end
      end
    end else begin
      case (style_reg)
        STY_SWAP:       r = is_upper(c) ? lower_of(c) : upper_of(c);
        STY_LOWER:      r = lower_of(c);
        STY_LOWERFIRST: r = none_out ? lower_of(c) : c;
        STY_UPPER:      r = upper_of(c);
        STY_UPPERFIRST: r = none_out ? upper_of(c) : c;
        STY_SPONGE:     r = odd_pos ? lower_of(c) : upper_of(c);
        default:        r = c;
      endcase
      emit(r);
      skip_lead    = 1'b0;
      none_out     = 1'b0;
      last_was_brk = 1'b0;
    end
    prev_lower = is_lower(c);
    odd_pos    = !odd_pos;
    // mark the end of the string, with a bare marker if nothing came out
    if (last) begin
      if (step_n == 0) begin
        step_res[0] = '{out_char: CH_NUL, out_valid: 1'b0, out_last: 1'b1};
        step_n = 1;
      end else begin
        step_res[step_n - 1].out_last = 1'b1;
      end
      clear_string_state();
    end
    for (int k = 0; k < step_n; k++) recased_q.push_back(step_res[k]);
  endfunction

  // Receiver: long hold when asked, else random stalls at the phase's rate
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    icc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (recased_q.size() == 0) begin
        $error("out_data: result beat with nothing expected, got %h", out_data);
        mismatch_count++;
      end else begin
        want = recased_q.pop_front();
        if (out_data.out_char !== want.out_char) begin
          $error("out_char: expected %h, got %h", want.out_char, out_data.out_char);
          mismatch_count++;
        end
        if (out_data.out_valid !== want.out_valid) begin
          $error("out_valid: expected %b, got %b", want.out_valid, out_data.out_valid);
          mismatch_count++;
        end
        if (out_data.out_last !== want.out_last) begin
          $error("out_last: expected %b, got %b", want.out_last, out_data.out_last);
          mismatch_count++;
        end
      end
    end
  end

  // Offer one beat and hold it until accepted
  task automatic send_beat(input logic [7:0] c, input logic last);
    in_data  <= '{in_char: c, in_last: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    recase_byte(c, last);
    items_sent++;
  endtask

  // Send a beat as part of a burst, with a random gap between bursts
  task automatic offer_char(input logic [7:0] c, input logic last);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    send_beat(c, last);
  endtask

  // Pause the sender until every expected beat is out, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (recased_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_style(input logic [4:0] s);
    cfg_wdata <= s;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    style_reg = s;
  endtask

  // Random identifier: optional leading blanks, then mostly letters with
  // separators, digits and some arbitrary bytes; finish sets the last mark
  task automatic send_string(input int len, input bit finish);
    int         lead;
    int         r;
    logic [7:0] c;
    lead = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i < lead + len; i++) begin
      r = $urandom_range(99);
      if (i < lead)     c = $urandom_range(1) ? CH_SPACE : CH_TAB;
      else if (r < 40)  c = 8'($urandom_range("a", "z"));
      else if (r < 60)  c = 8'($urandom_range("A", "Z"));
      else if (r < 68)  c = 8'($urandom_range("0", "9"));
      else if (r < 80) begin
        case ($urandom_range(3))
          0:       c = CH_DOT;
          1:       c = CH_USCORE;
          2:       c = CH_SLASH;
          default: c = CH_HYPHEN;
        endcase
      end
      else if (r < 88)  c = $urandom_range(1) ? CH_SPACE : CH_TAB;
      else if (r < 94)  c = 8'($urandom_range(33, 126));
      else              c = 8'($urandom_range(0, 255));
      offer_char(c, finish && (i == lead + len - 1));
    end
  endtask

  // Style after reset, before any write
  task automatic test_reset_style();
    send_beat("Z", 1'b1);
    wait_drained();
  endtask

  task automatic test_special_cases();
    // leading hyphen gives a leading break in camel
    write_style(STY_CAMEL);
    send_beat("-", 1'b0);
    send_beat("a", 1'b0);
    send_beat("B", 1'b1);
    wait_drained();
    // skipped blanks and a trailing separator: bare end marker
    write_style(STY_SNAKE);
    send_beat(CH_SPACE, 1'b0);
    send_beat(CH_TAB, 1'b0);
    send_beat("z", 1'b0);
    send_beat(CH_USCORE, 1'b1);
    wait_drained();
    // a lone blank
    write_style(STY_TITLE);
    send_beat(CH_SPACE, 1'b1);
    wait_drained();
    // camel hump in constant style
    write_style(STY_CONSTANT);
    send_beat("f", 1'b0);
    send_beat("o", 1'b0);
    send_beat("o", 1'b0);
    send_beat("B", 1'b0);
    send_beat("a", 1'b0);
    send_beat("r", 1'b1);
    wait_drained();
    // unused style code acts as copy, byte extremes
    write_style(5'd31);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    wait_drained();
    write_style(STY_SPONGE);
    send_beat("a", 1'b0);
    send_beat("Z", 1'b0);
    send_beat(8'h80, 1'b1);
    wait_drained();
    // style changed inside a string
    write_style(STY_UPPERFIRST);
    send_beat("x", 1'b0);
    wait_drained();
    write_style(STY_LOWERFIRST);
    send_beat("Q", 1'b1);
    wait_drained();
  endtask

  // Hold the output long enough for the block to fill and stall its input
  task automatic test_backpressure();
    write_style(STY_SNAKE);
    gaps_on     = 1'b0;
    stall_pct   = 0;
    hold_cycles = HOLD_LONG;
    repeat (6) send_string(8, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_strings();
    int         phase;
    int         len;
    logic [4:0] s;
    phase = 0;
    while (items_sent < ITEMS_TOTAL) begin
      wait_drained();
      if (phase <= STY_SPONGE) s = 5'(phase);
      else if (phase == STY_SPONGE + 1) s = 5'd31;
      else if ($urandom_range(6) == 0) s = 5'($urandom_range(19, 31));
      else s = 5'($urandom_range(0, 18));
      write_style(s);
      case ($urandom_range(3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 80;
      endcase
      gaps_on    = ($urandom_range(3) != 0);
      burst_left = 0;
      repeat ($urandom_range(2, 8)) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 10);
        send_string(len, 1'b1);
      end
      // leave a string open now and then, so the next style picks it up
      if ($urandom_range(4) == 0) send_string($urandom_range(1, 6), 1'b0);
      phase++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_style();
    test_special_cases();
    test_backpressure();
    test_random_strings();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #4_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
